// File: sv/swhc_pkg.sv
// Shared types and constants for the sliding-window hit counter.
// Used by swhc_ctrl, swhc_datapath and sliding_window_hit_counter_unit; no dependencies.
package swhc_pkg;

  localparam int TS_W  = 31;  // timestamp width
  localparam int CNT_W = 32;  // slot count and total width
  localparam int WIN_W = 10;  // window_length register width

  localparam logic [WIN_W-1:0] WINDOW_RESET = 10'd300;
  localparam logic [CNT_W-1:0] CNT_MAX      = 32'hFFFF_FFFF;

  localparam logic KIND_HIT   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;          // capture a new item
    logic expire;        // retire the oldest slot
    logic commit_hit;    // record the captured hit
    logic commit_query;  // publish the total
  } swhc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic expire_due;    // oldest live slot has aged out
    logic is_query;      // captured item is a query
  } swhc_status_t;

endpackage

// File: sv/sliding_window_hit_counter_unit.sv
// Top level of the sliding-window hit counter.
// Instantiates swhc_ctrl and swhc_datapath; depends on swhc_pkg.
//
// Usage:
//   Input beat: raise start with in_kind and in_timestamp; the beat is taken
//   at a rising edge where start is high and busy is low. in_kind 0 records
//   a hit, in_kind 1 queries. Timestamps should not decrease across beats.
//   Result beat: out_valid is high for exactly one cycle with out_hit_count,
//   the number of hits whose age is below window_length. Only queries give
//   a result. The receiver cannot stall, so results never back up.
//   Configuration: pulse cfg_write_en with cfg_window_length while idle;
//   it takes effect for the next beat.
// Timing:
//   An item is captured, then each expired slot is retired in turn, then
//   the item commits. The slot memory has a single read port, and the
//   expiry walk reads one slot a cycle. Each slot expires once. out_valid
//   rises at the edge where busy falls, so a query result is taken as the
//   input side is released.
// Reset:
//   rst_n (synchronous, active low) empties the ring, clears the total and
//   loads window_length with 300. The slot memory is not cleared; only
//   live slots ever affect the result.
module sliding_window_hit_counter_unit #(
  parameter int DEPTH = 512
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_kind,
  input  logic [swhc_pkg::TS_W-1:0]  in_timestamp,
  output logic                       out_valid,
  output logic [swhc_pkg::CNT_W-1:0] out_hit_count,
  input  logic                       cfg_write_en,
  input  logic [swhc_pkg::WIN_W-1:0] cfg_window_length
);
  import swhc_pkg::*;

  swhc_cmd_t    cmd;
  swhc_status_t status;

  // Sequence each beat: capture, walk expired slots, then commit.
  swhc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .status    (status),
    .cmd       (cmd)
  );

  // Hold the ring, the running total and the window register.
  swhc_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_write_en      (cfg_write_en),
    .cfg_window_length (cfg_window_length),
    .in_kind           (in_kind),
    .in_timestamp      (in_timestamp),
    .cmd               (cmd),
    .status            (status),
    .out_hit_count     (out_hit_count)
  );

endmodule

// File: sv/swhc_ctrl.sv
// Controller state machine for the sliding-window hit counter.
// Depends on swhc_pkg for the command and status structs.
module swhc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  output logic                  out_valid,
  input  swhc_pkg::swhc_status_t status,
  output swhc_pkg::swhc_cmd_t    cmd
);
  import swhc_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.expire_due) begin
          cmd.expire = 1'b1;
        end else begin
          // settle the item and release the input side
          cmd.commit_hit   = !status.is_query;
          cmd.commit_query = status.is_query;
          out_valid_nxt    = status.is_query;
          state_nxt        = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// File: sv/swhc_datapath.sv
// Datapath for the sliding-window hit counter: slot memory, ring pointers,
// running total and window register. Depends on swhc_pkg.
module swhc_datapath #(
  parameter int DEPTH = 512
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [swhc_pkg::WIN_W-1:0]    cfg_window_length,
  input  logic                          in_kind,
  input  logic [swhc_pkg::TS_W-1:0]     in_timestamp,
  input  swhc_pkg::swhc_cmd_t           cmd,
  output swhc_pkg::swhc_status_t        status,
  output logic [swhc_pkg::CNT_W-1:0]    out_hit_count
);
  import swhc_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [OCC_W-1:0] OCC_FULL  = OCC_W'(DEPTH);
  localparam logic [OCC_W-1:0] OCC_ONE   = OCC_W'(1);

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // Slot memory, one write and one registered read per cycle.
  logic [TS_W-1:0]  slot_time_mem  [DEPTH];
  logic [CNT_W-1:0] slot_count_mem [DEPTH];
  logic [TS_W-1:0]  rd_time_r;
  logic [CNT_W-1:0] rd_count_r;
  logic             wr_en;
  logic [PTR_W-1:0] wr_addr;
  logic [TS_W-1:0]  wr_time;
  logic [CNT_W-1:0] wr_count;
  logic [PTR_W-1:0] rd_addr;

  logic [WIN_W-1:0] window_length_r;
  logic             kind_r;
  logic [TS_W-1:0]  now_r;
  logic [PTR_W-1:0] oldest_r, oldest_nxt;
  logic [PTR_W-1:0] newest_r, newest_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [TS_W-1:0]  newest_time_r, newest_time_nxt;
  logic [CNT_W-1:0] newest_count_r, newest_count_nxt;
  logic [CNT_W-1:0] hit_count_r;
  logic [TS_W-1:0]  age;

  assign age = now_r - rd_time_r;

  assign status.expire_due = (occ_r != '0) && (now_r >= rd_time_r) &&
                             (age >= TS_W'(window_length_r));
  assign status.is_query   = (kind_r == KIND_QUERY);

  always_comb begin
    oldest_nxt       = oldest_r;
    newest_nxt       = newest_r;
    occ_nxt          = occ_r;
    total_nxt        = total_r;
    newest_time_nxt  = newest_time_r;
    newest_count_nxt = newest_count_r;
    wr_en            = 1'b0;
    wr_addr          = newest_r;
    wr_time          = now_r;
    wr_count         = CNT_W'(1);

    if (cmd.expire) begin
      // take the oldest count off the total, floor at zero
      total_nxt = (total_r >= rd_count_r) ? total_r - rd_count_r : '0;
      occ_nxt   = occ_r - OCC_ONE;
      if (occ_r > OCC_ONE) begin
        oldest_nxt = ring_next(oldest_r);
      end
    end

    if (cmd.commit_hit) begin
      wr_en = 1'b1;
      if (occ_r == '0) begin
        oldest_nxt = '0;
        newest_nxt = '0;
        occ_nxt    = OCC_ONE;
        wr_addr    = '0;
      end else if ((newest_time_r == now_r) || (occ_r >= OCC_FULL)) begin
        // merge into the newest slot
        wr_addr  = newest_r;
        wr_time  = newest_time_r;
        wr_count = sat_inc(newest_count_r);
      end else begin
        newest_nxt = ring_next(newest_r);
        wr_addr    = ring_next(newest_r);
        occ_nxt    = occ_r + OCC_ONE;
      end
      newest_time_nxt  = wr_time;
      newest_count_nxt = wr_count;
      total_nxt        = sat_inc(total_r);
    end
  end

  // Keep the oldest slot's contents in the read register at all times.
  assign rd_addr = oldest_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      slot_time_mem[wr_addr]  <= wr_time;
      slot_count_mem[wr_addr] <= wr_count;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_time_r  <= wr_time;
      rd_count_r <= wr_count;
    end else begin
      rd_time_r  <= slot_time_mem[rd_addr];
      rd_count_r <= slot_count_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_length_r <= WINDOW_RESET;
      oldest_r        <= '0;
      newest_r        <= '0;
      occ_r           <= '0;
      total_r         <= '0;
    end else begin
      if (cfg_write_en) begin
        window_length_r <= cfg_window_length;
      end
      oldest_r <= oldest_nxt;
      newest_r <= newest_nxt;
      occ_r    <= occ_nxt;
      total_r  <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_kind;
      now_r  <= in_timestamp;
    end
    if (cmd.commit_query) begin
      hit_count_r <= total_r;
    end
    newest_time_r  <= newest_time_nxt;
    newest_count_r <= newest_count_nxt;
  end

  assign out_hit_count = hit_count_r;

endmodule

// File: test/sliding_window_hit_counter_unit_test.sv
// Self-checking testbench for sliding_window_hit_counter_unit: a queued driver,
// a strobe monitor and a beat-level window predictor; needs swhc_pkg and the DUT.
`timescale 1ns / 100ps

module sliding_window_hit_counter_unit_test;
  import swhc_pkg::*;

  localparam int DEPTH = 512;
  // Longest legal item walks the whole ring; give each settle a bit more than that.
  localparam int DRAIN_CYCLES = DEPTH + 8;
  // Cycles with no beat of any kind before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 8 * DEPTH + 1000;
  localparam logic [TS_W-1:0] TS_MAX = {TS_W{1'b1}};

  typedef struct packed {
    logic            kind;
    logic [TS_W-1:0] timestamp;
  } counter_item_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic              in_kind = KIND_HIT;
  logic [TS_W-1:0]   in_timestamp = '0;
  logic              out_valid;
  logic [CNT_W-1:0]  out_hit_count;
  logic              cfg_write_en = 1'b0;
  logic [WIN_W-1:0]  cfg_window_length = WINDOW_RESET;

  sliding_window_hit_counter_unit #(.DEPTH(DEPTH)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_kind          (in_kind),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_hit_count    (out_hit_count),
    .cfg_write_en     (cfg_write_en),
    .cfg_window_length(cfg_window_length)
  );

  always #10 clk = ~clk;

  // Stimulus waiting for the driver, and hit counts waiting for the monitor.
  counter_item_t     pending_items[$];
  logic [CNT_W-1:0]  expected_counts[$];

  int errors = 0;
  int items_queued = 0;
  int items_accepted = 0;
  int counts_checked = 0;
  int window_writes = 0;
  int idle_cycles = 0;

  // Predictor state: a private copy of the ring, its total and the window register.
  logic [TS_W-1:0]   ring_time[DEPTH];
  logic [CNT_W-1:0]  ring_count[DEPTH];
  int                ring_head = 0;
  int                ring_tail = 0;
  int                ring_used = 0;
  logic [CNT_W-1:0]  window_sum = '0;
  logic [WIN_W-1:0]  window_len = WINDOW_RESET;
  int                peak_used = 0;
  int                full_merges = 0;

  // Advance the predicted ring by one accepted beat. Expire from the oldest end
  // first; a slot newer than the beat's time stops the walk. Queries produce
  // the total, hits merge into the newest slot or append a fresh one.
  task automatic count_in_window(input logic kind, input logic [TS_W-1:0] now);
    logic [TS_W-1:0] t;
    t = '0;
    while (ring_used > 0) begin
      t = ring_time[ring_head];
      if (now < t || (now - t) < window_len) break;
      window_sum = (window_sum >= ring_count[ring_head]) ?
                   window_sum - ring_count[ring_head] : '0;
      ring_used--;
      if (ring_used > 0) ring_head = (ring_head + 1) % DEPTH;
    end
    if (kind == KIND_QUERY) begin
      expected_counts.insert(expected_counts.size(), window_sum);
    end else begin
      if (ring_used == 0) begin
        ring_head = 0;
        ring_tail = 0;
        ring_time[0] = now;
        ring_count[0] = 1;
        ring_used = 1;
      end else if (ring_time[ring_tail] == now || ring_used >= DEPTH) begin
        // A full ring folds a new time into the newest slot.
        if (ring_time[ring_tail] != now) full_merges++;
        if (ring_count[ring_tail] != CNT_MAX) ring_count[ring_tail]++;
      end else begin
        ring_tail = (ring_tail + 1) % DEPTH;
        ring_time[ring_tail] = now;
        ring_count[ring_tail] = 1;
        ring_used++;
      end
      if (window_sum != CNT_MAX) window_sum++;
      if (ring_used > peak_used) peak_used = ring_used;
    end
  endtask

  // Driver: take the beat on start && !busy, then either hold, idle for a gap,
  // or present the next pending item. Bursts of random length alternate with
  // random gaps; a zero gap keeps start high across back-to-back beats.
  int            burst_left = 0;
  int            gap_left = 0;
  counter_item_t next_item;

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        count_in_window(in_kind, in_timestamp);
        items_accepted++;
      end
      // Hold the current beat while busy; otherwise pick what goes out next.
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          next_item = pending_items[0];
          pending_items.delete(0);
          in_kind <= next_item.kind;
          in_timestamp <= next_item.timestamp;
          start <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe must match the oldest predicted count.
  logic [CNT_W-1:0] want_count;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual hit_count=%0d",
                   $time, out_hit_count);
          errors++;
        end else begin
          want_count = expected_counts[0];
          expected_counts.delete(0);
          counts_checked++;
          if (out_hit_count !== want_count) begin
            $display("%0t: hit_count mismatch, expected %0d, actual %0d",
                     $time, want_count, out_hit_count);
            errors++;
          end
        end
      end else if (out_valid !== 1'b0) begin
        $display("%0t: out_valid unknown, expected 0 or 1, actual %b", $time, out_valid);
        errors++;
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on any port.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1 || cfg_write_en) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d results outstanding",
               $time, idle_cycles, expected_counts.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_item(input logic kind, input logic [TS_W-1:0] ts);
    counter_item_t item;
    item.kind = kind;
    item.timestamp = ts;
    pending_items.insert(pending_items.size(), item);
    items_queued++;
  endtask

  // Wait until every queued beat is taken and every count has come back, then
  // let the longest possible expiry walk finish before touching the register.
  task automatic settle();
    while (items_accepted != items_queued || expected_counts.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_window(input logic [WIN_W-1:0] w);
    @(posedge clk);
    cfg_write_en <= 1'b1;
    cfg_window_length <= w;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    window_len = w;
    window_writes++;
  endtask

  // Empty the ring: with a zero window, a query at the latest time expires
  // every slot, whatever order the timestamps came in.
  task automatic flush_ring();
    write_window('0);
    queue_item(KIND_QUERY, TS_MAX);
    settle();
  endtask

  // Random phase: mostly non-decreasing timestamps with repeats, short steps
  // mostly inside the window and jumps past it; a few small backward steps as noise.
  task automatic random_phase(input logic [WIN_W-1:0] w, input int n);
    longint ts;
    longint step;
    int     roll;
    logic   kind;
    write_window(w);
    ts = $urandom_range(0, 32'h7FFF_FFFF);
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) step = -longint'($urandom_range(1, 4));
      else if (roll < 8) step = w + $urandom_range(0, 2 * w + 2);
      else if (roll < 30) step = 0;
      else step = $urandom_range(1, w / 8 + 2);
      ts = ts + step;
      if (ts < 0) ts = 0;
      if (ts > longint'(TS_MAX)) ts = TS_MAX;
      kind = ($urandom_range(0, 99) < 35) ? KIND_QUERY : KIND_HIT;
      queue_item(kind, ts[TS_W-1:0]);
    end
    settle();
    flush_ring();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under the reset window of 300: empty query, merging on
    // equal times, expiry at exactly the window age, a time earlier than the
    // oldest slot, and a jump that expires everything.
    queue_item(KIND_QUERY, 31'd0);
    queue_item(KIND_HIT,   31'd0);
    queue_item(KIND_HIT,   31'd0);
    queue_item(KIND_QUERY, 31'd0);
    queue_item(KIND_HIT,   31'd5);
    queue_item(KIND_QUERY, 31'd299);
    queue_item(KIND_QUERY, 31'd300);
    queue_item(KIND_QUERY, 31'd305);
    queue_item(KIND_HIT,   31'd305);
    queue_item(KIND_HIT,   31'd304);
    queue_item(KIND_QUERY, 31'd304);
    queue_item(KIND_QUERY, 31'd605);
    queue_item(KIND_HIT,   31'd1000);
    queue_item(KIND_HIT,   31'd1000);
    queue_item(KIND_HIT,   31'd1001);
    queue_item(KIND_QUERY, 31'd1299);
    queue_item(KIND_QUERY, 31'd1300);
    queue_item(KIND_QUERY, 31'd1301);
    queue_item(KIND_HIT,   TS_MAX);
    queue_item(KIND_QUERY, TS_MAX);
    settle();
    flush_ring();

    // Fill the ring: alternate two times so nothing ever ages out, push past
    // DEPTH distinct slots and watch later hits fold into the newest one.
    write_window(10'd512);
    for (int i = 0; i < DEPTH + 16; i++) begin
      queue_item(KIND_HIT, (i % 2 == 0) ? 31'd5000 : 31'd4999);
      if (i % 64 == 63) queue_item(KIND_QUERY, 31'd5000);
    end
    queue_item(KIND_QUERY, 31'd5511);
    settle();
    flush_ring();

    // Random phases over the window extremes and a spread of values between.
    random_phase(10'd1, 140);
    random_phase(10'd512, 140);
    random_phase(10'd1023, 140);
    random_phase(10'd0, 80);
    random_phase(10'd7, 140);
    for (int p = 0; p < 4; p++)
      random_phase(WIN_W'($urandom_range(1, 512)), 150);

    $display("Drove %0d beats over %0d window settings and checked %0d counts.",
             items_accepted, window_writes, counts_checked);
    $display("Ring peaked at %0d slots; %0d hits folded into a full ring.",
             peak_used, full_merges);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
sv/swhc_pkg.sv
sv/swhc_ctrl.sv
sv/swhc_datapath.sv
sv/sliding_window_hit_counter_unit.sv
test/sliding_window_hit_counter_unit_test.sv
